// ===== rtl/sha256sh_pkg.sv =====
// Shared types, constants and the round constant table of the SHA-256 stream hasher.
// No dependencies; every other file imports this package.
package sha256sh_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  // Where the sequencer goes once a compression has been folded into the chain
  typedef enum logic [1:0] {
    NEXT_IDLE,
    NEXT_PAD,
    NEXT_OUT
  } next_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // Working variables a..h, index 0 is a
  typedef logic [7:0][31:0]  vars_t;
  // Sixteen-word message schedule window, index 0 is the oldest word
  typedef logic [15:0][31:0] sched_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastPos  = 6'd63;
  localparam logic [5:0] LastRnd  = 6'd63;
  localparam logic [2:0] LastWord = 3'd7;

  localparam vars_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sha256sh_round.sv =====
// One SHA-256 round plus the next message schedule word, reused for all 64 rounds.
// Depends on sha256sh_pkg for the working variable types and the round constants.
module sha256sh_round import sha256sh_pkg::*; (
  input  vars_t       vars_i,
  input  sched_t      sched_i,
  input  logic [5:0]  rnd_i,
  output vars_t       vars_o,
  output logic [31:0] w_new_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s0, s1, ch, mj, t1, t2, g0, g1, x15, x2;

  // Compress: the oldest window word is this round's schedule word
  always_comb begin
    s1 = rotr(vars_i[4], 6) ^ rotr(vars_i[4], 11) ^ rotr(vars_i[4], 25);
    ch = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    t1 = vars_i[7] + s1 + ch + round_k(rnd_i) + sched_i[0];
    s0 = rotr(vars_i[0], 2) ^ rotr(vars_i[0], 13) ^ rotr(vars_i[0], 22);
    mj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t2 = s0 + mj;
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

  // Expand: word sixteen places on from the oldest one
  always_comb begin
    x15     = sched_i[1];
    x2      = sched_i[14];
    g0      = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    g1      = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    w_new_o = sched_i[0] + g0 + sched_i[9] + g1;
  end

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher top level: byte intake, padding sequencer, round loop, digest output.
// Depends on sha256sh_pkg and sha256sh_round.
//
// Feed the message one byte per input transfer; mark the final transfer with
// end_of_message (its byte is optional, so an empty message is one end transfer
// with byte_valid low). A byte that does not complete a 64-byte block is stored
// in the block buffer. A byte that completes a block holds off input while
// the single shared round unit runs 64 rounds and the result is folded into
// the chaining words. An end transfer then writes the padding and length
// one byte per cycle (64 minus the bytes already in the block), runs one or
// two such compressions (the second after another pass that writes zeros and
// the length), and offers the eight digest words, word 0 first, one per output
// transfer; digest_last marks word 7. Input is not taken again until the last
// digest word has been transferred, after which the block is ready for the next
// message.
module sha256_stream_hasher_top import sha256sh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e      state_q, state_d;
  next_e       next_q, next_d;
  vars_t       chain_q, chain_d;
  vars_t       vars_q, vars_new;
  sched_t      sched_q;
  logic [31:0] w_new;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] msg_q, msg_d;
  logic [5:0]  pos_q, pos_d;
  logic        first_q, first_d;
  logic        len_ok_q, len_ok_d;
  logic        len_here;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        load_vars;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [7:0][7:0] len_bytes;

  assign len_bytes = {msg_q[60:0], 3'b000};

  sha256sh_round u_round (
    .vars_i  (vars_q),
    .sched_i (sched_q),
    .rnd_i   (rnd_q),
    .vars_o  (vars_new),
    .w_new_o (w_new)
  );

  // Ports
  assign in_stall_o              = (state_q != ST_IDLE);
  assign out_valid_o             = (state_q == ST_OUT);
  assign out_item_o.digest_word  = chain_q[idx_q];
  assign out_item_o.digest_last  = (idx_q == LastWord);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d   = state_q;
    next_d    = next_q;
    chain_d   = chain_q;
    fill_d    = fill_q;
    msg_d     = msg_q;
    pos_d     = pos_q;
    first_d   = first_q;
    len_ok_d  = len_ok_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    load_vars = 1'b0;
    wr_en     = 1'b0;
    wr_pos    = pos_q;
    wr_byte   = 8'h00;
    len_here  = first_q ? (pos_q < LenStart) : len_ok_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.byte_valid) begin
            wr_en   = 1'b1;
            wr_pos  = fill_q;
            wr_byte = in_item_i.data_byte;
            msg_d   = msg_q + 64'd1;
            if (fill_q == LastPos) begin
              // Block full: compress, then pad if this was the end
              fill_d    = 6'd0;
              load_vars = 1'b1;
              rnd_d     = 6'd0;
              state_d   = ST_ROUND;
              next_d    = in_item_i.end_of_message ? NEXT_PAD : NEXT_IDLE;
              first_d   = 1'b1;
              pos_d     = 6'd0;
            end else begin
              fill_d = fill_q + 6'd1;
              if (in_item_i.end_of_message) begin
                state_d = ST_PAD;
                first_d = 1'b1;
                pos_d   = fill_q + 6'd1;
              end
            end
          end else if (in_item_i.end_of_message) begin
            state_d = ST_PAD;
            first_d = 1'b1;
            pos_d   = fill_q;
          end
        end
      end
      ST_PAD: begin
        // Write the marker byte on the first pass, then zeros, then the bit length if it fits
        wr_en  = 1'b1;
        wr_pos = pos_q;
        if (first_q) begin
          wr_byte  = PadByte;
          first_d  = 1'b0;
          len_ok_d = (pos_q < LenStart);
        end else if (len_ok_q && (pos_q >= LenStart)) begin
          wr_byte = len_bytes[~pos_q[2:0]];
        end
        if (pos_q == LastPos) begin
          load_vars = 1'b1;
          rnd_d     = 6'd0;
          state_d   = ST_ROUND;
          pos_d     = 6'd0;
          next_d    = len_here ? NEXT_OUT : NEXT_PAD;
          len_ok_d  = 1'b1;
        end else begin
          pos_d = pos_q + 6'd1;
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRnd) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int j = 0; j < 8; j++) begin
          chain_d[j] = chain_q[j] + vars_q[j];
        end
        idx_d = 3'd0;
        case (next_q)
          NEXT_IDLE: state_d = ST_IDLE;
          NEXT_PAD:  state_d = ST_PAD;
          NEXT_OUT:  state_d = ST_OUT;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastWord) begin
            // Digest delivered: start over for the next message
            chain_d = InitHash;
            msg_d   = 64'd0;
            fill_d  = 6'd0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state and the chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      next_q   <= NEXT_IDLE;
      chain_q  <= InitHash;
      fill_q   <= 6'd0;
      msg_q    <= 64'd0;
      pos_q    <= 6'd0;
      first_q  <= 1'b0;
      len_ok_q <= 1'b0;
      rnd_q    <= 6'd0;
      idx_q    <= 3'd0;
    end else begin
      state_q  <= state_d;
      next_q   <= next_d;
      chain_q  <= chain_d;
      fill_q   <= fill_d;
      msg_q    <= msg_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
      len_ok_q <= len_ok_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
    end
  end

  // Block buffer doubles as the schedule window: fill by byte, advance by round
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i + 1];
      end
      sched_q[15] <= w_new;
    end else if (wr_en) begin
      sched_q[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // Working variables: load from the chain, then advance one round a cycle
  always_ff @(posedge clk_i) begin
    if (load_vars) begin
      vars_q <= chain_q;
    end else if (state_q == ST_ROUND) begin
      vars_q <= vars_new;
    end
  end

endmodule

// ===== bench/tb_sha256_stream_hasher_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_stream_hasher_top: byte driver, digest monitor and a SHA-256 predictor.
// Depends on sha256sh_pkg for the transfer types and on the RTL top level.
module tb_sha256_stream_hasher_top;
  import sha256sh_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 600;
  localparam int DrainCycles = 200;
  localparam int MaxReports = 10;
  localparam int PhaseQuota = 58;
  localparam logic [7:0] PadMark = 8'h80;
  localparam int LenFieldPos = 56;

  localparam logic [0:7][31:0] InitChain = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths that open each random phase: one and two final compressions
  localparam int BoundaryLen [4] = '{55, 56, 63, 64};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  sha256_stream_hasher_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Pending input transfers and the digest words still owed by the block
  in_item_t  pend_q [$];
  out_item_t digest_q [$];

  // Predictor state
  logic [31:0] chain_w [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] msg_len;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  n_queued = 0;
  int  n_errors = 0;
  int  n_bytes = 0;
  int  n_idle = 0;
  int  n_msgs = 0;
  int  n_words = 0;
  int  n_cycles = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int j = 0; j < 8; j++) chain_w[j] = InitChain[j];
    block_fill = 0;
    msg_len = '0;
  endfunction

  // Run the 64 rounds over msg_block and fold the result into the chain
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] x15, x2, wr, t1, t2;
    int j, r;
    for (j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (j = 0; j < 8; j++) v[j] = chain_w[j];
    for (r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        x15 = w[(r - 15) & 15];
        x2 = w[(r - 2) & 15];
        wr = w[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + w[(r - 7) & 15]
           + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        w[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (j = 0; j < 8; j++) chain_w[j] = chain_w[j] + v[j];
  endfunction

  // Take one transfer into the predictor; on end of message queue the digest
  function automatic void absorb_transfer(input in_item_t it);
    logic [63:0] bit_len;
    out_item_t   word;
    int          i;
    if (it.byte_valid) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      msg_len = msg_len + 64'd1;
      n_bytes++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end else if (!it.end_of_message) begin
      n_idle++;
    end
    if (!it.end_of_message) return;
    bit_len = msg_len << 3;
    msg_block[block_fill] = PadMark;
    block_fill++;
    // No room left for the length field: close this block and open another
    if (block_fill > LenFieldPos) begin
      for (i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
      compress_block();
      block_fill = 0;
    end
    for (i = block_fill; i < LenFieldPos; i++) msg_block[i] = 8'h00;
    for (i = 0; i < 8; i++) msg_block[63 - i] = bit_len[8*i +: 8];
    compress_block();
    for (i = 0; i < 8; i++) begin
      word.digest_word = chain_w[i];
      word.digest_last = (i == 7);
      digest_q = {digest_q, word};
    end
    n_msgs++;
    restart_message();
  endfunction

  function automatic void flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void push_item(input bit bv, input bit eom, input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.byte_valid = bv;
    it.end_of_message = eom;
    pend_q = {pend_q, it};
    if (bv || eom) n_queued++;
  endfunction

  // Queue one message of random content, with stray idle transfers mixed in
  function automatic void push_message(input int len);
    bit fold_end;
    fold_end = (len > 0) && $urandom_range(1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) push_item(1'b0, 1'b0, 8'($urandom_range(255)));
      push_item(1'b1, fold_end && (k == len - 1), 8'($urandom_range(255)));
    end
    if (!fold_end) push_item(1'b0, 1'b1, 8'($urandom_range(255)));
  endfunction

  // Sender pause: nothing in flight and every digest word returned
  task automatic wait_all_done();
    while (pend_q.size() != 0 || in_valid_i || digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: offer the next transfer once the current one has gone
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i <= pend_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started by a toggle of hold_req
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predict on input transfers, check output transfers, watch the clock
  always @(posedge clk_i) begin
    out_item_t want;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) absorb_transfer(in_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words++;
      if (digest_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected digest word %h last %b",
                                out_item_o.digest_word, out_item_o.digest_last));
      end else begin
        want = digest_q.pop_front();
        if (out_item_o.digest_word !== want.digest_word)
          flag_mismatch($sformatf("digest_word expected %h got %h",
                                  want.digest_word, out_item_o.digest_word));
        if (out_item_o.digest_last !== want.digest_last)
          flag_mismatch($sformatf("digest_last expected %b got %b",
                                  want.digest_last, out_item_o.digest_last));
      end
    end
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               n_cycles, digest_q.size());
      $display("FAIL sha256_stream_hasher_top");
      $finish;
    end
  end

  initial begin
    int quota;
    restart_message();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle transfer, empty message, single bytes at both extremes,
    // end carried on a byte and on a bare end transfer
    push_item(1'b0, 1'b0, 8'hff);
    push_item(1'b0, 1'b1, 8'h00);
    push_item(1'b1, 1'b1, 8'h00);
    push_item(1'b1, 1'b0, 8'hff);
    push_item(1'b0, 1'b1, 8'hff);
    push_item(1'b1, 1'b0, 8'h61);
    push_item(1'b1, 1'b0, 8'h62);
    push_item(1'b1, 1'b1, 8'h63);
    push_item(1'b1, 1'b0, 8'h55);
    push_item(1'b0, 1'b0, 8'h00);
    push_item(1'b1, 1'b0, 8'haa);
    push_item(1'b1, 1'b1, 8'h80);
    push_item(1'b0, 1'b1, 8'h7f);
    wait_all_done();

    // Random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // Hold the receiver off so the block backs up into its input
      if (phase == 0 || phase == 3) begin
        @(posedge clk_i);
        hold_req = ~hold_req;
      end
      quota = n_queued + PhaseQuota;
      push_message(BoundaryLen[phase]);
      while (n_queued < quota) push_message($urandom_range(12));
      wait_all_done();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Hashed %0d messages from %0d bytes (%0d idle transfers), %0d digest words checked",
             n_msgs, n_bytes, n_idle, n_words);
    $display("Lengths included empty, single byte and the 55/56/63/64 byte padding edges");
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("PASS sha256_stream_hasher_top");
    end else begin
      $display("%0d mismatches, %0d digest words outstanding", n_errors, digest_q.size());
      $display("FAIL sha256_stream_hasher_top");
    end
    $finish;
  end

endmodule
